// ===== sv/ckd_pkg.sv =====
// ----------------------------------------------------------------------------
// ckd_pkg
// Shared types, character codes and key codes for the cursor key decoder.
// ----------------------------------------------------------------------------
package ckd_pkg;

	localparam int FIELD_BITS_DEF = 20;

	// character codes
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_SEMI  = 8'h3B;
	localparam logic [7:0] CH_TILDE = 8'h7E;
	localparam logic [7:0] CH_U     = 8'h75;
	localparam logic [7:0] CH_SS3   = 8'h4F;
	localparam logic [7:0] CH_CSI   = 8'h5B;
	localparam logic [7:0] CH_A     = 8'h41;
	localparam logic [7:0] CH_B     = 8'h42;
	localparam logic [7:0] CH_C     = 8'h43;
	localparam logic [7:0] CH_D     = 8'h44;
	localparam logic [7:0] CH_H     = 8'h48;
	localparam logic [7:0] CH_F     = 8'h46;

	// functional key codes of the 'u' form
	localparam int KP_HOME = 57360;
	localparam int KP_END  = 57361;
	localparam int KP_PGUP = 57362;
	localparam int KP_PGDN = 57363;

	typedef enum logic [2:0] {
		KEY_UP    = 3'd0,
		KEY_DOWN  = 3'd1,
		KEY_RIGHT = 3'd2,
		KEY_LEFT  = 3'd3,
		KEY_HOME  = 3'd4,
		KEY_END   = 3'd5,
		KEY_PGUP  = 3'd6,
		KEY_PGDN  = 3'd7
	} key_t;

	// accumulator status seen by the decision logic
	typedef struct packed {
		logic [3:0] byte_count;
		logic [7:0] lead_byte;
		logic [2:0] first_digits;
		logic [2:0] second_digits;
		logic [1:0] semicolon_count;
		logic       bad_body;
	} acc_status_t;

endpackage

// ===== sv/ckd_accum.sv =====
// ----------------------------------------------------------------------------
// ckd_accum
// Per-sequence accumulators: lead byte, two decimal fields, digit and
// semicolon counts; cleared after the last byte of each sequence.
// ----------------------------------------------------------------------------
module ckd_accum import ckd_pkg::*; #(
	parameter int FIELD_BITS = FIELD_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  step,
	input  logic [7:0]            seq_byte,
	input  logic                  is_last,
	output acc_status_t           status,
	output logic [FIELD_BITS-1:0] first_field,
	output logic [FIELD_BITS-1:0] second_field
);

	acc_status_t           st_q;
	logic [FIELD_BITS-1:0] first_q;
	logic [FIELD_BITS-1:0] second_q;

	logic                  is_digit;
	logic [3:0]            digit;
	logic [FIELD_BITS-1:0] sel_field;
	logic [FIELD_BITS+3:0] next_val;
	logic                  overflow;

	assign is_digit  = (seq_byte >= CH_ZERO) && (seq_byte <= CH_NINE);
	assign digit     = 4'(seq_byte - CH_ZERO);
	assign sel_field = (st_q.semicolon_count == 2'd0) ? first_q : second_q;

	// field * 10 + digit
	assign next_val = {1'b0, sel_field, 3'b000} + {3'b000, sel_field, 1'b0}
		+ {{FIELD_BITS{1'b0}}, digit};
	assign overflow = |next_val[FIELD_BITS+3:FIELD_BITS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q     <= '0;
			first_q  <= '0;
			second_q <= '0;
		end else if (step) begin
			if (is_last) begin
				st_q     <= '0;
				first_q  <= '0;
				second_q <= '0;
			end else begin
				if (st_q.byte_count == 4'd0) begin
					st_q.lead_byte <= seq_byte;
				end else if (is_digit) begin
					if (st_q.semicolon_count == 2'd0) begin
						if (overflow) st_q.bad_body <= 1'b1;
						else first_q <= next_val[FIELD_BITS-1:0];
						if (st_q.first_digits != 3'd7)
							st_q.first_digits <= st_q.first_digits + 3'd1;
					end else if (st_q.semicolon_count == 2'd1) begin
						if (overflow) st_q.bad_body <= 1'b1;
						else second_q <= next_val[FIELD_BITS-1:0];
						if (st_q.second_digits != 3'd7)
							st_q.second_digits <= st_q.second_digits + 3'd1;
					end
				end else if (seq_byte == CH_SEMI) begin
					if (st_q.semicolon_count != 2'd3)
						st_q.semicolon_count <= st_q.semicolon_count + 2'd1;
				end else begin
					st_q.bad_body <= 1'b1;
				end
				if (st_q.byte_count != 4'd15)
					st_q.byte_count <= st_q.byte_count + 4'd1;
			end
		end
	end

	assign status       = st_q;
	assign first_field  = first_q;
	assign second_field = second_q;

`ifndef ASSERT_OFF
	a_clear_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		step && is_last |=> st_q.byte_count == 4'd0 && st_q.semicolon_count == 2'd0
			&& !st_q.bad_body)
		else $error("accumulators not cleared after last byte");
	a_digits_need_lead: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.byte_count == 4'd0 |-> st_q.first_digits == 3'd0
			&& st_q.semicolon_count == 2'd0)
		else $error("body state without a lead byte");
	a_second_needs_semi: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.semicolon_count == 2'd0 |-> st_q.second_digits == 3'd0)
		else $error("second field digits before any semicolon");
`endif

endmodule

// ===== sv/cursor_key_sequence_decoder.sv =====
// ----------------------------------------------------------------------------
// cursor_key_sequence_decoder
// Decodes terminal cursor key sequences (bytes after ESC) into a key code
// and shift, alt and ctrl flags.
// ----------------------------------------------------------------------------
// One byte is accepted per cycle with no gaps. Each byte goes into an input
// register and from there updates the sequence accumulators, and the byte
// marked last loads the result register, so a result passes through the input
// register and then the result register. A waiting result only holds back a
// following last byte, and the input behind it while that byte waits in the
// input register; other bytes keep flowing. Every sequence gives exactly one
// result: recognized with the key and modifiers, or not recognized with all
// fields 0. Decimal fields wider than FIELD_BITS reject the sequence.
module cursor_key_sequence_decoder import ckd_pkg::*; #(
	parameter int FIELD_BITS = FIELD_BITS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] seq_byte,
	input  logic       is_last,
	output logic       out_valid,
	input  logic       out_ready,
	output logic       recognized,
	output logic [2:0] key_code,
	output logic       shift_held,
	output logic       alt_held,
	output logic       ctrl_held
);

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       last_s1;
	logic       advance;

	acc_status_t           st;
	logic [FIELD_BITS-1:0] first_field;
	logic [FIELD_BITS-1:0] second_field;

	logic       rec_c;
	logic [2:0] key_c;
	logic [2:0] mods_c;
	logic       one_mod;
	logic       letter_ok;
	logic [2:0] letter_k;
	logic       tilde_ok;
	logic [2:0] tilde_k;
	logic       code_ok;
	logic [2:0] code_k;

	logic       out_valid_q;
	logic       rec_q;
	logic [2:0] key_q;
	logic [2:0] mods_q;

	// a last byte needs room in the result register
	assign advance  = valid_s1 && (!last_s1 || !out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= seq_byte;
			last_s1 <= is_last;
		end
	end

	ckd_accum #(.FIELD_BITS(FIELD_BITS)) u_accum (
		.clk          (clk),
		.arst_n       (arst_n),
		.step         (advance),
		.seq_byte     (byte_s1),
		.is_last      (last_s1),
		.status       (st),
		.first_field  (first_field),
		.second_field (second_field)
	);

	always_comb begin
		letter_ok = 1'b1;
		letter_k  = KEY_UP;
		unique case (byte_s1)
			CH_A:    letter_k = KEY_UP;
			CH_B:    letter_k = KEY_DOWN;
			CH_C:    letter_k = KEY_RIGHT;
			CH_D:    letter_k = KEY_LEFT;
			CH_H:    letter_k = KEY_HOME;
			CH_F:    letter_k = KEY_END;
			default: letter_ok = 1'b0;
		endcase
	end

	always_comb begin
		tilde_ok = 1'b1;
		tilde_k  = KEY_HOME;
		if (first_field == FIELD_BITS'(1)) tilde_k = KEY_HOME;
		else if (first_field == FIELD_BITS'(4)) tilde_k = KEY_END;
		else if (first_field == FIELD_BITS'(5)) tilde_k = KEY_PGUP;
		else if (first_field == FIELD_BITS'(6)) tilde_k = KEY_PGDN;
		else tilde_ok = 1'b0;
	end

	always_comb begin
		code_ok = 1'b1;
		code_k  = tilde_k;
		if (!tilde_ok) begin
			if (first_field == FIELD_BITS'(KP_HOME)) code_k = KEY_HOME;
			else if (first_field == FIELD_BITS'(KP_END)) code_k = KEY_END;
			else if (first_field == FIELD_BITS'(KP_PGUP)) code_k = KEY_PGUP;
			else if (first_field == FIELD_BITS'(KP_PGDN)) code_k = KEY_PGDN;
			else code_ok = 1'b0;
		end
	end

	assign one_mod = (st.semicolon_count == 2'd1) && (st.second_digits == 3'd1)
		&& (second_field >= FIELD_BITS'(2)) && (second_field <= FIELD_BITS'(8));

	always_comb begin
		rec_c  = 1'b0;
		key_c  = KEY_UP;
		mods_c = 3'd0;
		if (st.byte_count == 4'd0) begin
			rec_c = 1'b0;
		end else if (st.lead_byte == CH_SS3) begin
			rec_c = (st.byte_count == 4'd1) && letter_ok;
			key_c = letter_k;
		end else if (st.lead_byte != CH_CSI || st.bad_body) begin
			rec_c = 1'b0;
		end else if (byte_s1 == CH_U) begin
			key_c = code_k;
			if (st.first_digits != 3'd0 && code_ok) begin
				if (st.semicolon_count == 2'd0) begin
					rec_c = 1'b1;
				end else if (st.semicolon_count == 2'd1 && st.second_digits != 3'd0
					&& second_field != '0) begin
					rec_c  = 1'b1;
					mods_c = second_field[2:0] - 3'd1;
				end
			end
		end else if (byte_s1 == CH_TILDE) begin
			key_c = tilde_k;
			if (st.first_digits == 3'd1 && tilde_ok) begin
				if (st.semicolon_count == 2'd0) begin
					rec_c = 1'b1;
				end else if (one_mod) begin
					rec_c  = 1'b1;
					mods_c = second_field[2:0] - 3'd1;
				end
			end
		end else if (letter_ok) begin
			key_c = letter_k;
			if (st.semicolon_count == 2'd0 && st.first_digits == 3'd0) begin
				rec_c = 1'b1;
			end else if (st.first_digits == 3'd1 && first_field == FIELD_BITS'(1)
				&& one_mod) begin
				rec_c  = 1'b1;
				mods_c = second_field[2:0] - 3'd1;
			end
		end
		// rejected sequences report all zero
		if (!rec_c) begin
			key_c  = KEY_UP;
			mods_c = 3'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && last_s1) begin
			rec_q  <= rec_c;
			key_q  <= key_c;
			mods_q <= mods_c;
		end
	end

	assign out_valid  = out_valid_q;
	assign recognized = rec_q;
	assign key_code   = key_q;
	assign shift_held = mods_q[0];
	assign alt_held   = mods_q[1];
	assign ctrl_held  = mods_q[2];

`ifndef ASSERT_OFF
	a_last_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		advance && last_s1 |=> out_valid_q)
		else $error("last byte did not load a result");
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		advance && last_s1 && out_valid_q |-> out_ready)
		else $error("pending result overwritten");
	a_reject_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !rec_q |-> key_q == 3'd0 && mods_q == 3'd0)
		else $error("rejected item carries key or modifier bits");
	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> valid_s1 && last_s1)
		else $error("input stage stalled without a pending last byte");
`endif

endmodule

// ===== tb/tb_cursor_key_sequence_decoder.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_cursor_key_sequence_decoder
// Feeds terminal key sequences byte by byte into the decoder and checks every
// decoded key against a cycle-free model kept inside the bench. A short run of
// hand-picked sequences comes first, then random sequences that are mostly
// well formed, with noise and corrupted sequences mixed in. Both handshakes
// idle in random bursts, except near the end of the run.
// ----------------------------------------------------------------------------
module tb_cursor_key_sequence_decoder;
	import ckd_pkg::*;

	localparam int STALL_LIMIT = 2000;
	localparam int CALM_TAIL   = 60;
	localparam int RANDOM_BYTES = 650;
	localparam longint unsigned FIELD_MAX = (64'd1 << FIELD_BITS_DEF) - 1;

	typedef logic [7:0] byte_q_t[$];

	typedef struct {
		logic [7:0] data;
		bit         last;
	} seq_item_t;

	typedef struct {
		bit   recognized;
		key_t key;
		bit   shift;
		bit   alt;
		bit   ctrl;
	} key_event_t;

	logic       clk        = 1'b0;
	logic       arst_n     = 1'b0;
	logic       in_valid   = 1'b0;
	logic       in_ready;
	logic [7:0] seq_byte   = 8'h00;
	logic       is_last    = 1'b0;
	logic       out_valid;
	logic       out_ready  = 1'b0;
	logic       recognized;
	logic [2:0] key_code;
	logic       shift_held;
	logic       alt_held;
	logic       ctrl_held;

	cursor_key_sequence_decoder dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.seq_byte   (seq_byte),
		.is_last    (is_last),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.recognized (recognized),
		.key_code   (key_code),
		.shift_held (shift_held),
		.alt_held   (alt_held),
		.ctrl_held  (ctrl_held)
	);

	always #5 clk = ~clk;

	seq_item_t  byte_stream[$];
	key_event_t pending_keys[$];
	int         bytes_queued = 0;
	int         err_count    = 0;
	int         idle_cycles  = 0;
	int         in_gap       = 0;
	int         out_hold     = 0;
	bit         in_taken     = 1'b0;
	seq_item_t  next_item;
	key_event_t want;

	// decoder state as the bench sees it
	logic [3:0]  seq_len;
	logic [7:0]  lead_char;
	logic [63:0] num_a;
	logic [63:0] num_b;
	logic [2:0]  digits_a;
	logic [2:0]  digits_b;
	logic [1:0]  semis;
	bit          body_bad;

	task automatic clear_sequence();
		seq_len   = '0;
		lead_char = '0;
		num_a     = '0;
		num_b     = '0;
		digits_a  = '0;
		digits_b  = '0;
		semis     = '0;
		body_bad  = 1'b0;
	endtask

	task automatic add_digit(inout logic [63:0] field, inout logic [2:0] digits, input int d);
		logic [63:0] v;
		v = field * 10 + d;
		if (v > FIELD_MAX)
			body_bad = 1'b1;
		else
			field = v;
		if (digits < 3'd7)
			digits++;
	endtask

	function automatic int letter_key(input logic [7:0] b);
		case (b)
			CH_A:    return int'(KEY_UP);
			CH_B:    return int'(KEY_DOWN);
			CH_C:    return int'(KEY_RIGHT);
			CH_D:    return int'(KEY_LEFT);
			CH_H:    return int'(KEY_HOME);
			CH_F:    return int'(KEY_END);
			default: return -1;
		endcase
	endfunction

	function automatic int tilde_key(input logic [63:0] n);
		case (n)
			64'd1:   return int'(KEY_HOME);
			64'd4:   return int'(KEY_END);
			64'd5:   return int'(KEY_PGUP);
			64'd6:   return int'(KEY_PGDN);
			default: return -1;
		endcase
	endfunction

	function automatic int code_key(input logic [63:0] c);
		case (c)
			64'd1, 64'(KP_HOME): return int'(KEY_HOME);
			64'd4, 64'(KP_END):  return int'(KEY_END);
			64'd5, 64'(KP_PGUP): return int'(KEY_PGUP);
			64'd6, 64'(KP_PGDN): return int'(KEY_PGDN);
			default:             return -1;
		endcase
	endfunction

	// key for the sequence ending in lastb, or -1 when rejected
	function automatic int decide_key(input logic [7:0] lastb, output logic [2:0] mods);
		bit          one_mod;
		int          k;
		logic [63:0] m;
		mods = '0;
		if (seq_len == 0)
			return -1;
		if (lead_char == CH_SS3)
			return (seq_len == 1) ? letter_key(lastb) : -1;
		if (lead_char != CH_CSI || body_bad)
			return -1;
		one_mod = semis == 1 && digits_b == 1 && num_b >= 2 && num_b <= 8;
		if (lastb == CH_U) begin
			m = 1;
			if (digits_a == 0)
				return -1;
			if (semis == 1) begin
				if (digits_b == 0 || num_b == 0)
					return -1;
				m = num_b;
			end else if (semis != 0) begin
				return -1;
			end
			k = code_key(num_a);
			if (k < 0)
				return -1;
			mods = 3'(m - 1);
			return k;
		end
		if (lastb == CH_TILDE) begin
			if (digits_a != 1)
				return -1;
			k = tilde_key(num_a);
			if (k < 0)
				return -1;
			if (semis == 0)
				return k;
			if (!one_mod)
				return -1;
			mods = 3'(num_b - 1);
			return k;
		end
		k = letter_key(lastb);
		if (k < 0)
			return -1;
		if (semis == 0 && digits_a == 0)
			return k;
		if (digits_a == 1 && num_a == 1 && one_mod) begin
			mods = 3'(num_b - 1);
			return k;
		end
		return -1;
	endfunction

	task automatic predict_key_byte(input logic [7:0] b, input bit lst);
		key_event_t ev;
		logic [2:0] mods;
		int         k;
		if (lst) begin
			k = decide_key(b, mods);
			ev.recognized = k >= 0;
			ev.key        = (k >= 0) ? key_t'(k[2:0]) : KEY_UP;
			ev.shift      = (k >= 0) && mods[0];
			ev.alt        = (k >= 0) && mods[1];
			ev.ctrl       = (k >= 0) && mods[2];
			pending_keys.push_back(ev);
			clear_sequence();
		end else begin
			if (seq_len == 0) begin
				lead_char = b;
			end else if (b >= CH_ZERO && b <= CH_NINE) begin
				if (semis == 0)
					add_digit(num_a, digits_a, int'(b - CH_ZERO));
				else if (semis == 1)
					add_digit(num_b, digits_b, int'(b - CH_ZERO));
			end else if (b == CH_SEMI) begin
				if (semis < 2'd3)
					semis++;
			end else begin
				body_bad = 1'b1;
			end
			if (seq_len < 4'd15)
				seq_len++;
		end
	endtask

	task automatic flag_mismatch(input string msg);
		$display("mismatch at %0t: %s", $time, msg);
		err_count++;
	endtask

	function automatic byte_q_t text_bytes(input string s);
		byte_q_t q;
		for (int i = 0; i < s.len(); i++)
			q.push_back(s[i]);
		return q;
	endfunction

	task automatic queue_seq(input byte_q_t q);
		seq_item_t it;
		foreach (q[i]) begin
			it.data = q[i];
			it.last = (i == q.size() - 1);
			byte_stream.push_back(it);
			bytes_queued++;
		end
	endtask

	function automatic string pick_letter();
		string letters = "ABCDHF";
		int    idx;
		idx = $urandom_range(0, 5);
		if ($urandom_range(0, 9) == 0)
			return $sformatf("%c", 8'($urandom_range(33, 126)));
		return letters.substr(idx, idx);
	endfunction

	function automatic longint unsigned pick_code();
		case ($urandom_range(0, 11))
			0:       return 1;
			1:       return 4;
			2:       return 5;
			3:       return 6;
			4, 5:    return KP_HOME + $urandom_range(0, 3);
			6:       return $urandom_range(0, 9);
			7:       return $urandom_range(0, 70000);
			8:       return FIELD_MAX;
			9:       return FIELD_MAX + 1;
			10:      return $urandom_range(0, 99999999);
			default: return KP_HOME - 1 + $urandom_range(0, 6);
		endcase
	endfunction

	task automatic add_random_sequence();
		byte_q_t q;
		string   s;
		int      pos;
		int      nz;
		int      a;
		int      m;
		case ($urandom_range(0, 9))
			0, 1: begin
				s = {"O", pick_letter()};
				if ($urandom_range(0, 7) == 0)
					s = {s, pick_letter()};
				q = text_bytes(s);
			end
			2, 3: begin
				s = "[";
				if ($urandom_range(0, 1)) begin
					a = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 9) : 1;
					m = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 9) : $urandom_range(2, 8);
					s = {s, $sformatf("%0d;%0d", a, m)};
				end
				s = {s, pick_letter()};
				q = text_bytes(s);
			end
			4, 5: begin
				case ($urandom_range(0, 4))
					0:       a = 1;
					1:       a = 4;
					2:       a = 5;
					3:       a = 6;
					default: a = $urandom_range(0, 99);
				endcase
				s = "[";
				if ($urandom_range(0, 9) == 0)
					s = {s, "0"};
				s = {s, $sformatf("%0d", a)};
				if ($urandom_range(0, 1))
					s = {s, $sformatf(";%0d", ($urandom_range(0, 3) == 0) ?
						$urandom_range(0, 12) : $urandom_range(2, 8))};
				s = {s, "~"};
				q = text_bytes(s);
			end
			6, 7: begin
				nz = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 12) : 0;
				s = "[";
				repeat (nz) s = {s, "0"};
				if ($urandom_range(0, 15) != 0)
					s = {s, $sformatf("%0d", pick_code())};
				if ($urandom_range(0, 2) != 0)
					s = {s, $sformatf(";%0d", $urandom_range(0, 12))};
				if ($urandom_range(0, 9) == 0)
					s = {s, $sformatf(";%0d", $urandom_range(0, 9))};
				s = {s, "u"};
				q = text_bytes(s);
			end
			8: begin
				// raw noise, long enough at times to saturate the byte count
				repeat ($urandom_range(1, 20)) q.push_back(8'($urandom_range(0, 255)));
			end
			default: begin
				s = $sformatf("[%0d;%0du", pick_code(), $urandom_range(1, 8));
				q = text_bytes(s);
				pos = $urandom_range(0, q.size() - 1);
				q[pos] = 8'($urandom_range(0, 255));
			end
		endcase
		queue_seq(q);
	endtask

	// scoreboard and model update on every accepted item
	always @(posedge clk) begin
		if (arst_n) begin
			in_taken = in_valid && in_ready;
			if (in_taken)
				predict_key_byte(seq_byte, is_last);
			if (out_valid && out_ready) begin
				if (pending_keys.size() == 0) begin
					flag_mismatch("result with no sequence waiting");
				end else begin
					want = pending_keys.pop_front();
					if (recognized !== want.recognized)
						flag_mismatch($sformatf("recognized %b, want %b",
							recognized, want.recognized));
					if (key_code !== want.key)
						flag_mismatch($sformatf("key_code %0d, want %0d", key_code, want.key));
					if (shift_held !== want.shift)
						flag_mismatch($sformatf("shift_held %b, want %b", shift_held, want.shift));
					if (alt_held !== want.alt)
						flag_mismatch($sformatf("alt_held %b, want %b", alt_held, want.alt));
					if (ctrl_held !== want.ctrl)
						flag_mismatch($sformatf("ctrl_held %b, want %b", ctrl_held, want.ctrl));
				end
			end
		end
	end

	// watchdog on handshake progress
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("tb_cursor_key_sequence_decoder NOT OK");
				$finish;
			end
		end
	end

	// input driver
	always @(negedge clk) begin
		if (arst_n && (!in_valid || in_taken)) begin
			if (in_gap > 0) begin
				in_gap   <= in_gap - 1;
				in_valid <= 1'b0;
			end else if (byte_stream.size() == 0) begin
				in_valid <= 1'b0;
			end else if (byte_stream.size() > CALM_TAIL && $urandom_range(0, 11) == 0) begin
				in_gap   <= $urandom_range(0, 16);
				in_valid <= 1'b0;
			end else begin
				next_item = byte_stream.pop_front();
				seq_byte  <= next_item.data;
				is_last   <= next_item.last;
				in_valid  <= 1'b1;
			end
		end
	end

	// result side back-pressure
	always @(negedge clk) begin
		if (arst_n) begin
			if (out_hold > 0) begin
				out_hold  <= out_hold - 1;
				out_ready <= 1'b0;
			end else if (byte_stream.size() > CALM_TAIL && $urandom_range(0, 9) == 0) begin
				out_hold  <= $urandom_range(0, 16);
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	initial begin
		clear_sequence();

		queue_seq(text_bytes("OH"));
		queue_seq('{8'h00});
		queue_seq('{8'hFF});
		queue_seq(text_bytes("[1;8F"));
		queue_seq(text_bytes("[6;2~"));
		// leading zero in the u form
		queue_seq(text_bytes("[01u"));
		// one past the largest value the field holds
		queue_seq(text_bytes($sformatf("[%0du", FIELD_MAX + 1)));
		// digits after a second semicolon
		queue_seq(text_bytes("[1;2;3u"));

		while (bytes_queued < RANDOM_BYTES)
			add_random_sequence();

		repeat (7) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;

		while (byte_stream.size() != 0 || in_valid)
			@(posedge clk);
		while (pending_keys.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);

		if (err_count == 0)
			$display("tb_cursor_key_sequence_decoder OK");
		else
			$display("tb_cursor_key_sequence_decoder NOT OK");
		$finish;
	end

endmodule

// ===== files.f =====
sv/ckd_pkg.sv
sv/ckd_accum.sv
sv/cursor_key_sequence_decoder.sv
tb/tb_cursor_key_sequence_decoder.sv
